/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the supervisor checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted (reset active low)
`define LDS_ASSERT(name, ck, rstn, prop) \
    name: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("line disconnect supervisor check failed");

// same, on the usual clk / rst_n pair
`define LDS_CHECK(name, prop) \
    `LDS_ASSERT(name, clk, rst_n, prop)

`endif

/* rtl/lds_pkg.sv */
// ----------------------------------------------------------------------------
// lds_pkg
// shared types, codes and helpers of the line disconnect supervisor
// ----------------------------------------------------------------------------
package lds_pkg;

    localparam int TICK_WIDTH   = 16;
    localparam int LIMIT_WIDTH  = 16;
    localparam int CMP_WIDTH    = (TICK_WIDTH > LIMIT_WIDTH) ? TICK_WIDTH : LIMIT_WIDTH;
    localparam int MAX_RESULTS  = 4;
    localparam int CNT_WIDTH    = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_WIDTH   = $clog2(MAX_RESULTS);
    localparam int RUN_DEPTH    = 2;
    localparam int RUN_PTR_W    = $clog2(RUN_DEPTH);
    localparam int RUN_FILL_W   = $clog2(RUN_DEPTH + 1);
    localparam int ADDR_WIDTH   = 4;
    localparam int DATA_WIDTH   = 32;

    typedef enum logic [2:0] {
        CMD_STATUS   = 3'd0,
        CMD_CARRIER  = 3'd1,
        CMD_WATCHDOG = 3'd2,
        CMD_TICK     = 3'd3,
        CMD_ARM      = 3'd4,
        CMD_CLEAR    = 3'd5
    } cmd_t;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_DISC    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [1:0] REASON_NORMAL  = 2'd0;
    localparam logic [1:0] REASON_CPC     = 2'd1;
    localparam logic [1:0] REASON_TIMEOUT = 2'd2;

    localparam logic [1:0] REG_WINK   = 2'd0;
    localparam logic [1:0] REG_DEFER  = 2'd1;
    localparam logic [1:0] REG_CUTOFF = 2'd2;

    localparam logic [7:0] ST_IDLE_A   = 8'h60;
    localparam logic [7:0] ST_IDLE_B   = 8'h62;
    localparam logic [7:0] ST_INTERR   = 8'h64;
    localparam logic [7:0] ST_CONNECT  = 8'h66;
    localparam logic [7:0] ST_REV_ZERO = 8'h68;
    localparam logic [7:0] ST_REV_ONE  = 8'h6a;
    localparam logic [7:0] ST_AUX_A    = 8'h6c;
    localparam logic [7:0] ST_AUX_B    = 8'h6e;
    localparam logic [7:0] ST_WINK     = 8'h8c;
    localparam logic [7:0] ST_DEFER    = 8'h8e;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] wink_limit;
        logic [LIMIT_WIDTH-1:0] defer_limit;
        logic [LIMIT_WIDTH-1:0] cutoff_limit;
    } lds_cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] status;
        logic [1:0] reason;
    } lds_slot_t;

    typedef struct packed {
        logic [CNT_WIDTH-1:0]              count;
        lds_slot_t [MAX_RESULTS-1:0]       slots;
        logic [63:0]                       cycle;
        logic [15:0]                       pc;
    } lds_run_t;

    function automatic logic is_profile_code(input logic [7:0] code);
        logic hit;
        hit = (code == ST_IDLE_A) || (code == ST_IDLE_B) || (code == ST_INTERR)
           || (code == ST_CONNECT) || (code == ST_REV_ZERO) || (code == ST_REV_ONE)
           || (code == ST_AUX_A) || (code == ST_AUX_B) || (code == ST_WINK)
           || (code == ST_DEFER);
        return hit;
    endfunction

endpackage

/* rtl/lds_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lds_cfg_regs
// apb limit registers of the supervisor (wink, defer, cutoff)
// ----------------------------------------------------------------------------
module lds_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lds_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [lds_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [lds_pkg::DATA_WIDTH-1:0] prdata,
    output logic                          pready,
    output lds_pkg::lds_cfg_t             cfg
);
    import lds_pkg::*;

    lds_cfg_t   cfg_reg;
    lds_cfg_t   cfg_next;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_WINK:   cfg_next.wink_limit   = pwdata[LIMIT_WIDTH-1:0];
                REG_DEFER:  cfg_next.defer_limit  = pwdata[LIMIT_WIDTH-1:0];
                REG_CUTOFF: cfg_next.cutoff_limit = pwdata[LIMIT_WIDTH-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WINK:   prdata = DATA_WIDTH'(cfg_reg.wink_limit);
            REG_DEFER:  prdata = DATA_WIDTH'(cfg_reg.defer_limit);
            REG_CUTOFF: prdata = DATA_WIDTH'(cfg_reg.cutoff_limit);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

/* rtl/lds_core.sv */
// ----------------------------------------------------------------------------
// lds_core
// supervision state and per-request evaluation into a run of results
// ----------------------------------------------------------------------------
module lds_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [2:0]        cmd,
    input  logic [7:0]        status_value,
    input  logic              carrier_level,
    input  logic [63:0]       cycle_stamp,
    input  logic [15:0]       prog_counter,
    input  lds_pkg::lds_cfg_t cfg,
    output lds_pkg::lds_run_t run
);
    import lds_pkg::*;

    typedef struct packed {
        logic                  carrier_seen;
        logic                  line_connected;
        logic                  interrupted;
        logic                  saw_rev_zero;
        logic                  disc_sent;
        logic                  timer_armed;
        logic [TICK_WIDTH-1:0] tick_count;
        logic                  wink_sent;
        logic                  defer_sent;
    } lds_state_t;

    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    lds_state_t state_reg;
    lds_state_t state_next;

    always_comb
    begin
        lds_slot_t [MAX_RESULTS-1:0] slots;
        logic [CNT_WIDTH-1:0]        n;
        logic [TICK_WIDTH-1:0]       tick_inc;
        logic [CMP_WIDTH-1:0]        tick_ext;
        logic                        wink_hit;
        logic                        defer_hit;
        logic                        cutoff_hit;

        state_next = state_reg;
        slots      = '0;
        n          = '0;
        tick_inc   = (state_reg.tick_count == TICK_MAX) ? state_reg.tick_count
                                                        : state_reg.tick_count + 1'b1;
        tick_ext   = CMP_WIDTH'(tick_inc);
        wink_hit   = (cfg.wink_limit != '0) && !state_reg.wink_sent
                  && (tick_ext >= CMP_WIDTH'(cfg.wink_limit));
        defer_hit  = (cfg.defer_limit != '0) && !state_reg.defer_sent
                  && (tick_ext >= CMP_WIDTH'(cfg.defer_limit));
        cutoff_hit = (cfg.cutoff_limit != '0) && !state_reg.disc_sent
                  && (tick_ext >= CMP_WIDTH'(cfg.cutoff_limit));

        case (cmd_t'(cmd))
            CMD_STATUS:
            begin
                if (is_profile_code(status_value))
                begin
                    slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_STATUS, status: status_value,
                                                 reason: REASON_NORMAL};
                    n = n + 1'b1;
                    if (status_value == ST_CONNECT)
                        state_next.line_connected = 1'b1;
                    if (status_value == ST_INTERR && state_reg.line_connected)
                        state_next.interrupted = 1'b1;
                    if (status_value == ST_REV_ZERO)
                        state_next.saw_rev_zero = 1'b1;
                    else if (status_value == ST_REV_ONE && state_reg.saw_rev_zero)
                    begin
                        state_next.saw_rev_zero = 1'b0;
                        if (!state_reg.disc_sent)
                        begin
                            slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_DISC, status: 8'h00,
                                                         reason: REASON_CPC};
                            n = n + 1'b1;
                            state_next.disc_sent = 1'b1;
                        end
                    end
                end
            end
            CMD_CARRIER:
            begin
                if (!carrier_level && state_reg.carrier_seen && state_reg.line_connected
                    && state_reg.interrupted && !state_reg.disc_sent)
                begin
                    slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_DISC, status: 8'h00,
                                                 reason: REASON_NORMAL};
                    n = n + 1'b1;
                    state_next.disc_sent = 1'b1;
                end
                state_next.carrier_seen = carrier_level;
            end
            CMD_WATCHDOG:
            begin
                slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_TIMEOUT, status: 8'h00,
                                             reason: REASON_NORMAL};
                n = n + 1'b1;
                if (!state_reg.disc_sent)
                begin
                    slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_DISC, status: 8'h00,
                                                 reason: REASON_TIMEOUT};
                    n = n + 1'b1;
                    state_next.disc_sent = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (state_reg.timer_armed)
                begin
                    state_next.tick_count = tick_inc;
                    if (wink_hit)
                    begin
                        slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_STATUS, status: ST_WINK,
                                                     reason: REASON_NORMAL};
                        n = n + 1'b1;
                        state_next.wink_sent = 1'b1;
                    end
                    if (defer_hit)
                    begin
                        slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_STATUS, status: ST_DEFER,
                                                     reason: REASON_NORMAL};
                        n = n + 1'b1;
                        state_next.defer_sent = 1'b1;
                    end
                    if (cutoff_hit)
                    begin
                        slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_TIMEOUT, status: 8'h00,
                                                     reason: REASON_NORMAL};
                        n = n + 1'b1;
                        slots[n[SLOT_WIDTH-1:0]] = '{kind: KIND_DISC, status: 8'h00,
                                                     reason: REASON_TIMEOUT};
                        n = n + 1'b1;
                        state_next.disc_sent   = 1'b1;
                        state_next.timer_armed = 1'b0;
                    end
                end
            end
            CMD_ARM:
            begin
                state_next.timer_armed = 1'b1;
                state_next.tick_count  = '0;
                state_next.wink_sent   = 1'b0;
                state_next.defer_sent  = 1'b0;
            end
            CMD_CLEAR:
            begin
                state_next = '0;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        run.count = n;
        run.slots = slots;
        run.cycle = cycle_stamp;
        run.pc    = prog_counter;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

endmodule

/* rtl/lds_run_fifo.sv */
// ----------------------------------------------------------------------------
// lds_run_fifo
// two-deep queue of result runs, drained one result per handshake
// ----------------------------------------------------------------------------
module lds_run_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lds_pkg::lds_run_t push_run,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_kind,
    output logic [7:0]        out_status,
    output logic [1:0]        disc_reason,
    output logic [63:0]       out_cycle,
    output logic [15:0]       out_pc,
    output logic              last_of_run
);
    import lds_pkg::*;

    lds_run_t                runs [RUN_DEPTH];
    logic [RUN_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [RUN_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [RUN_FILL_W-1:0]   fill_reg, fill_next;
    logic [SLOT_WIDTH-1:0]   sub_reg, sub_next;
    lds_run_t                head;
    lds_slot_t               head_slot;
    logic                    pop_result;
    logic                    pop_run;

    assign head        = runs[rd_ptr_reg];
    assign head_slot   = head.slots[sub_reg];
    assign full        = (fill_reg == RUN_FILL_W'(RUN_DEPTH));
    assign out_valid   = (fill_reg != '0);
    assign event_kind  = head_slot.kind;
    assign out_status  = head_slot.status;
    assign disc_reason = head_slot.reason;
    assign out_cycle   = head.cycle;
    assign out_pc      = head.pc;
    assign last_of_run = (CNT_WIDTH'(sub_reg) == head.count - 1'b1);
    assign pop_result  = out_valid && !out_stall;
    assign pop_run     = pop_result && last_of_run;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        sub_next    = sub_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop_run)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            sub_next    = '0;
        end
        else if (pop_result)
            sub_next = sub_reg + 1'b1;
        // fill holds when both or neither happen
        if (push && !pop_run)
            fill_next = fill_reg + 1'b1;
        else if (pop_run && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            runs[wr_ptr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            sub_reg    <= sub_next;
        end
    end

endmodule

/* rtl/line_disconnect_supervisor.sv */
// ----------------------------------------------------------------------------
// line_disconnect_supervisor
// watches supervision events of a telephone line and reports disconnects
// ----------------------------------------------------------------------------
// usage:
//   requests enter on in_valid / in_stall: cmd plus status_value,
//   carrier_level, cycle_stamp and prog_counter; a request is taken at a
//   clock edge with in_valid high and in_stall low
//   each request yields zero to four results on out_valid / out_stall; the
//   last one of a request carries last_of_run, and all carry the request's
//   cycle stamp and program counter
//   the supervision state is updated, and the request's results are
//   written into the run queue, at the accepting edge
//   throughput: one request per cycle while the queue has room; results
//   leave one at a time, so the output side sets the sustained rate when
//   requests give several results. a two-run queue lets a request enter
//   while results still wait; when out_stall is high the current result
//   holds; in_stall rises only once both run slots of the queue are occupied
//   limits (wink, defer, cutoff) sit on the apb port at 0x0, 0x4, 0x8; the
//   user must write them only while the block is idle, unchecked by the block
//   reset (rst_n low, asynchronous) clears the supervision state, the limits
//   and the result queue
// ----------------------------------------------------------------------------
module line_disconnect_supervisor (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     cmd,
    input  logic [7:0]                     status_value,
    input  logic                           carrier_level,
    input  logic [63:0]                    cycle_stamp,
    input  logic [15:0]                    prog_counter,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     event_kind,
    output logic [7:0]                     out_status,
    output logic [1:0]                     disc_reason,
    output logic [63:0]                    out_cycle,
    output logic [15:0]                    out_pc,
    output logic                           last_of_run,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lds_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [lds_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [lds_pkg::DATA_WIDTH-1:0] prdata,
    output logic                           pready
);
    import lds_pkg::*;

    lds_cfg_t cfg;
    lds_run_t run;
    logic     accept;
    logic     fifo_full;
    logic     push;

    // a request is taken whenever the run queue has a free slot
    assign in_stall = fifo_full;
    assign accept   = in_valid && !in_stall;
    // requests that give no result only move the state
    assign push     = accept && (run.count != '0);

    lds_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state flags and tick counter, evaluated in one pass per request
    lds_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (cmd),
        .status_value  (status_value),
        .carrier_level (carrier_level),
        .cycle_stamp   (cycle_stamp),
        .prog_counter  (prog_counter),
        .cfg           (cfg),
        .run           (run)
    );

    // registered result runs, handed out one result at a time
    lds_run_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_run    (run),
        .full        (fifo_full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .out_status  (out_status),
        .disc_reason (disc_reason),
        .out_cycle   (out_cycle),
        .out_pc      (out_pc),
        .last_of_run (last_of_run)
    );

endmodule

/* rtl/lds_checker.sv */
// ----------------------------------------------------------------------------
// lds_checker
// port-level checks on the supervisor result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  event_kind,
    input logic [7:0]  out_status,
    input logic [1:0]  disc_reason,
    input logic [63:0] out_cycle,
    input logic [15:0] out_pc,
    input logic        last_of_run
);
    import lds_pkg::*;

    logic [92:0] result_word;

    // all result fields side by side
    assign result_word = {event_kind, out_status, disc_reason, out_cycle, out_pc, last_of_run};

    // stalled result holds
    `LDS_CHECK(a_hold, out_valid && out_stall |=> out_valid && $stable(result_word))

    // a disconnect always closes its run
    `LDS_CHECK(a_disc_last, out_valid && event_kind == KIND_DISC |-> last_of_run)

    // only status results carry a code
    `LDS_CHECK(a_status_only, out_valid && event_kind != KIND_STATUS |-> out_status == 8'h00)

    // a reason only comes with a disconnect
    `LDS_CHECK(a_reason_only, out_valid && event_kind != KIND_DISC |-> disc_reason == REASON_NORMAL)

endmodule

bind line_disconnect_supervisor lds_checker u_lds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_kind  (event_kind),
    .out_status  (out_status),
    .disc_reason (disc_reason),
    .out_cycle   (out_cycle),
    .out_pc      (out_pc),
    .last_of_run (last_of_run)
);
